// ----- sv/assert_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- sv/rea_pkg.sv -----
// Package: constants and types of the extent allocator.
package rea_pkg;
  localparam int unsigned TableDepth = 256;
  localparam logic [31:0] RefLimit = 32'hFFFF_FFFE;

  localparam logic [2:0] FnReserve = 3'd0;
  localparam logic [2:0] FnFree    = 3'd1;
  localparam logic [2:0] FnRef     = 3'd2;
  localparam logic [2:0] FnCommit  = 3'd3;
  localparam logic [2:0] FnLookup  = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StInvalid  = 3'd1;
  localparam logic [2:0] StRange    = 3'd2;
  localparam logic [2:0] StNoSpace  = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;

  localparam logic RegFirst = 1'b0;
  localparam logic RegLast  = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] refs;
    logic [31:0] gen;
  } extent_t;
endpackage

// ----- sv/refcounted_extent_allocator_unit.sv -----
// Top level: reference-counted first-fit extent allocator.
//
// The extent table sits in one synchronous memory (one entry per extent, sorted
// by start block, with a registered read port). Each request is run by a
// sequencer over that memory. Lookup, free and ref scan the table one entry a
// cycle; free and ref write back the hit. Reserve scans for a first-fit gap,
// then moves the entries above the new slot one place up, from the top down,
// reading each entry and then writing it one place higher, and writes the new
// extent into the opened slot. Commit compacts the table in one pass, reading
// entry r and writing entry w. Unknown functions answer with an invalid
// status. The result is held in an output register; the next request is taken
// only once the result has been delivered, and a pending register write goes
// ahead of a waiting request. Entries of the memory never written read as
// anything, but only entries below the stored count are ever looked at, so no
// clearing pass is needed after reset.
// Registers: index 0 first data block, 1 last data block.
`include "assert_macros.svh"
module refcounted_extent_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = rea_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [3:0]  device_index_i,
  input  logic [31:0] address_block_i,
  input  logic [31:0] nblocks_i,
  input  logic [31:0] generation_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] extent_base_o,
  output logic [31:0] extent_size_o,
  output logic [31:0] ref_count_o,
  output logic [31:0] live_total_o,
  output logic [31:0] held_total_o
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SHit   = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SShWr  = 3'd4;
  localparam logic [2:0] SIns   = 3'd5;
  localparam logic [2:0] SDone  = 3'd6;

  // Extent memory: one write port, one registered read port.
  rea_pkg::extent_t mem_q [TABLE_DEPTH];
  rea_pkg::extent_t rdata_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  rea_pkg::extent_t wdata;
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [2:0]  state_q, state_d;
  logic [31:0] first_q, last_q;
  logic [CW-1:0] count_q, count_d;
  logic [31:0] alloc_q, alloc_d, pend_q, pend_d;
  logic [2:0]  fn_q;
  logic [3:0]  dev_q;
  logic [31:0] blk_q, nb_q, gen_q;
  logic [CW-1:0] r_q, r_d, w_q, w_d;   // scan / read index, write index
  logic        rv_q, rv_d;             // rdata_q holds entry r_q-1
  logic [32:0] cur_q, cur_d;
  logic [32:0] hs_q;
  logic [31:0] where_q, where_d;
  logic [CW-1:0] pos_q, pos_d;
  logic        ov_q, ov_d;
  logic [2:0]  st_q, st_d;
  logic [31:0] sb_q, sb_d, ln_q, ln_d, rc_q, rc_d;

  // Give a register write priority over a request waiting in the same cycle.
  assign cfg_ready_o = (state_q == SIdle) && !ov_q;
  assign in_ready_o  = (state_q == SIdle) && !ov_q && !cfg_valid_i;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign extent_base_o = sb_q;
  assign extent_size_o = ln_q;
  assign ref_count_o = rc_q;
  assign live_total_o = alloc_q;
  assign held_total_o = pend_q;

  logic        hint_ok;
  logic [32:0] s33, e33, last33, need33;
  assign s33 = {1'b0, rdata_q.start};
  assign e33 = s33 + {1'b0, rdata_q.length};
  assign last33 = {1'b0, last_q};
  assign need33 = {1'b0, nb_q};

  always_comb begin
    state_d = state_q; count_d = count_q; alloc_d = alloc_q; pend_d = pend_q;
    r_d = r_q; w_d = w_q; rv_d = 1'b0; cur_d = cur_q; where_d = where_q;
    pos_d = pos_q; ov_d = ov_q; st_d = st_q; sb_d = sb_q; ln_d = ln_q; rc_d = rc_q;
    we = 1'b0; waddr = '0; wdata = rdata_q; raddr = r_q[AW-1:0];
    hint_ok = 1'b0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        r_d = '0; w_d = '0;
        if (in_valid_i && in_ready_o) begin
          state_d = SScan;
          raddr = '0;
          r_d = CW'(1);
          rv_d = 1'b1;
          cur_d = {1'b0, first_q};
          sb_d = '0; ln_d = '0; rc_d = '0;
        end
      end
      SScan: begin
        // rdata_q holds entry r_q-1 when rv_q and r_q-1 < count
        raddr = r_q[AW-1:0];
        r_d = r_q + CW'(1);
        rv_d = 1'b1;
        if (!rv_q || (r_q - CW'(1)) >= count_q) begin
          // end of table
          state_d = SDone;
          st_d = rea_pkg::StOk;
          case (fn_q)
            rea_pkg::FnReserve: begin
              if (nb_q == '0) st_d = rea_pkg::StInvalid;
              else if (cur_q <= last33 && (last33 - cur_q + 33'd1) >= need33) begin
                if (count_q >= DepthC) st_d = rea_pkg::StFull;
                else begin
                  hint_ok = (hs_q != '0) && hs_q >= cur_q && hs_q <= last33 &&
                            (last33 - hs_q + 33'd1) >= need33;
                  where_d = hint_ok ? hs_q[31:0] : cur_q[31:0];
                  pos_d = count_q;
                  state_d = SIns;
                end
              end else st_d = rea_pkg::StNoSpace;
            end
            rea_pkg::FnCommit: count_d = w_q;
            rea_pkg::FnFree, rea_pkg::FnRef, rea_pkg::FnLookup:
              st_d = (dev_q != '0) ? rea_pkg::StInvalid : rea_pkg::StNotFound;
            default: st_d = rea_pkg::StInvalid;
          endcase
        end else begin
          case (fn_q)
            rea_pkg::FnReserve: begin
              if (nb_q == '0) begin
                state_d = SDone; st_d = rea_pkg::StInvalid;
              end else if (hs_q != '0 && hs_q >= cur_q && hs_q < s33 &&
                           (s33 - hs_q) >= need33) begin
                hint_ok = 1'b1;
              end else if (s33 > cur_q && (s33 - cur_q) >= need33) begin
                hint_ok = 1'b1;
              end else begin
                cur_d = e33;
              end
              if (hint_ok) begin
                if (count_q >= DepthC) begin
                  state_d = SDone; st_d = rea_pkg::StFull;
                end else begin
                  where_d = (hs_q != '0 && hs_q >= cur_q && hs_q < s33 &&
                             (s33 - hs_q) >= need33) ? hs_q[31:0] : cur_q[31:0];
                  pos_d = r_q - CW'(1);
                  r_d = count_q;   // shift from the top down
                  state_d = (count_q == r_q - CW'(1)) ? SIns : SShift;
                end
              end
            end
            rea_pkg::FnCommit: begin
              if (rdata_q.refs == '0 && rdata_q.gen < gen_q) begin
                pend_d = pend_q - rdata_q.length;
              end else begin
                we = 1'b1; waddr = w_q[AW-1:0]; w_d = w_q + CW'(1);
              end
            end
            rea_pkg::FnFree, rea_pkg::FnRef, rea_pkg::FnLookup: begin
              if (dev_q != '0) begin
                state_d = SDone; st_d = rea_pkg::StInvalid;
              end else if (rdata_q.start == blk_q) begin
                state_d = SDone;
                pos_d = r_q - CW'(1);
                st_d = rea_pkg::StOk;
                if (fn_q == rea_pkg::FnLookup) begin
                  ln_d = rdata_q.length; rc_d = rdata_q.refs;
                end else if (rdata_q.refs == '0) begin
                  st_d = rea_pkg::StInvalid;
                end else if (fn_q == rea_pkg::FnRef) begin
                  if (rdata_q.refs >= rea_pkg::RefLimit) st_d = rea_pkg::StRange;
                  else begin
                    we = 1'b1; waddr = pos_d[AW-1:0];
                    wdata.refs = rdata_q.refs + 32'd1;
                  end
                end else begin
                  we = 1'b1; waddr = pos_d[AW-1:0];
                  wdata.refs = rdata_q.refs - 32'd1;
                  if (rdata_q.refs == 32'd1) begin
                    wdata.gen = gen_q;
                    alloc_d = alloc_q - rdata_q.length;
                    pend_d = pend_q + rdata_q.length;
                  end
                end
              end
            end
            default: begin
              state_d = SDone; st_d = rea_pkg::StInvalid;
            end
          endcase
        end
      end
      SShift: begin
        // read entry r_q-1, next cycle write it to r_q
        raddr = AW'(r_q - CW'(1));
        state_d = SShWr;
      end
      SShWr: begin
        we = 1'b1; waddr = r_q[AW-1:0];
        r_d = r_q - CW'(1);
        state_d = (r_d == pos_q) ? SIns : SShift;
      end
      SIns: begin
        we = 1'b1; waddr = pos_q[AW-1:0];
        wdata.start = where_q; wdata.length = nb_q;
        wdata.refs = 32'd1; wdata.gen = '0;
        count_d = count_q + CW'(1);
        alloc_d = alloc_q + nb_q;
        sb_d = where_q; st_d = rea_pkg::StOk;
        state_d = SDone;
      end
      SDone: begin
        ov_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; first_q <= '0; last_q <= '1; count_q <= '0;
      alloc_q <= '0; pend_q <= '0; ov_q <= 1'b0; rv_q <= 1'b0;
      r_q <= '0; w_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; alloc_q <= alloc_d;
      pend_q <= pend_d; ov_q <= ov_d; rv_q <= rv_d; r_q <= r_d; w_q <= w_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == rea_pkg::RegFirst) first_q <= cfg_data_i;
        else last_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; where_q <= where_d; pos_q <= pos_d;
    st_q <= st_d; sb_q <= sb_d; ln_q <= ln_d; rc_q <= rc_d;
    if (in_valid_i && in_ready_o) begin
      fn_q <= func_i; dev_q <= device_index_i; blk_q <= address_block_i;
      nb_q <= nblocks_i; gen_q <= generation_i;
      hs_q <= (address_block_i != '0 && device_index_i == '0 &&
               address_block_i >= first_q && address_block_i <= last_q) ?
              {1'b0, address_block_i} : '0;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > DepthC)
  `ASSERT_IMPL(a_out_after_done, clk_i, rst_ni, (state_q == SDone) |=> ov_q)
  `ASSERT_NEVER(a_busy_not_ready, clk_i, rst_ni, (state_q != SIdle) && in_ready_o)
endmodule

// ----- tb/tb_refcounted_extent_allocator_unit.sv -----
// Testbench for the reference-counted first-fit extent allocator.
`timescale 1ns / 100ps
module tb_refcounted_extent_allocator_unit;

  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned PhaseItems = 80;

  typedef struct {
    logic [2:0]  func;
    logic [3:0]  dev;
    logic [31:0] addr;
    logic [31:0] nblk;
    logic [31:0] gen;
    bit          typed;    // status below is known by inspection
    logic [2:0]  status;
  } stim_row_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] refs;
    logic [31:0] alloc;
    logic [31:0] pend;
    bit          typed;
    logic [2:0]  typed_status;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  func_i;
  logic [3:0]  device_index_i;
  logic [31:0] address_block_i;
  logic [31:0] nblocks_i;
  logic [31:0] generation_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] extent_base_o;
  logic [31:0] extent_size_o;
  logic [31:0] ref_count_o;
  logic [31:0] live_total_o;
  logic [31:0] held_total_o;

  refcounted_extent_allocator_unit dut (.*);

  // Mirror of the extent table, the data area registers and the running totals.
  logic [31:0] ext_start [rea_pkg::TableDepth];
  logic [31:0] ext_len   [rea_pkg::TableDepth];
  logic [31:0] ext_refs  [rea_pkg::TableDepth];
  logic [31:0] ext_gen   [rea_pkg::TableDepth];
  int          ext_cnt;
  logic [31:0] area_first, area_last;
  logic [31:0] alloc_total, pend_total;

  reply_t    awaited_replies[$];
  stim_row_t directed_rows[$];
  int        errors;
  int unsigned cycles = 0;
  int        send_idle_pct, recv_stall_pct;
  int        random_sent;
  logic [31:0] epoch;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Give up at the cycle limit so a hung block cannot stall the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver side: stall the result channel at random, changed at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int find_extent(logic [31:0] blk);
    for (int i = 0; i < ext_cnt; i++) begin
      if (ext_start[i] == blk) return i;
    end
    return -1;
  endfunction

  // First-fit search with hint; insert the new extent at its sorted position.
  function automatic logic [2:0] mirror_reserve(logic [3:0] dev, logic [31:0] hint,
                                                logic [31:0] n, output logic [31:0] where_o);
    logic [63:0] hs, cursor, need, last, s, where;
    int          pos;
    bit          found;
    where_o = '0;
    hs = '0;
    need = 64'(n);
    last = 64'(area_last);
    found = 1'b0;
    pos = 0;
    where = '0;
    if (n == 0) return rea_pkg::StInvalid;
    if (hint != 0 && dev == 0 && hint >= area_first && hint <= area_last) hs = 64'(hint);
    cursor = 64'(area_first);
    for (int i = 0; i < ext_cnt; i++) begin
      s = 64'(ext_start[i]);
      if (hs != 0 && hs >= cursor && hs < s && s - hs >= need) begin
        found = 1'b1; where = hs; pos = i;
        break;
      end
      if (s > cursor && s - cursor >= need) begin
        found = 1'b1; where = cursor; pos = i;
        break;
      end
      cursor = s + 64'(ext_len[i]);
    end
    if (!found && cursor <= last && last - cursor + 64'd1 >= need) begin
      found = 1'b1;
      pos = ext_cnt;
      if (hs != 0 && hs >= cursor && hs <= last && last - hs + 64'd1 >= need) where = hs;
      else where = cursor;
    end
    if (!found) return rea_pkg::StNoSpace;
    if (ext_cnt >= rea_pkg::TableDepth) return rea_pkg::StFull;
    for (int i = ext_cnt; i > pos; i--) begin
      ext_start[i] = ext_start[i-1];
      ext_len[i]   = ext_len[i-1];
      ext_refs[i]  = ext_refs[i-1];
      ext_gen[i]   = ext_gen[i-1];
    end
    ext_start[pos] = where[31:0];
    ext_len[pos]   = n;
    ext_refs[pos]  = 32'd1;
    ext_gen[pos]   = '0;
    ext_cnt++;
    alloc_total += n;
    where_o = where[31:0];
    return rea_pkg::StOk;
  endfunction

  // Drop pending extents older than the committed generation, compacting in place.
  function automatic void mirror_commit(logic [31:0] gen);
    int w;
    w = 0;
    for (int r = 0; r < ext_cnt; r++) begin
      if (ext_refs[r] == 0 && ext_gen[r] < gen) begin
        pend_total -= ext_len[r];
        continue;
      end
      ext_start[w] = ext_start[r];
      ext_len[w]   = ext_len[r];
      ext_refs[w]  = ext_refs[r];
      ext_gen[w]   = ext_gen[r];
      w++;
    end
    ext_cnt = w;
  endfunction

  function automatic reply_t predict_request(stim_row_t r);
    reply_t e;
    int     k;
    e = '{default: '0};
    e.typed = r.typed;
    e.typed_status = r.status;
    case (r.func)
      rea_pkg::FnReserve: e.status = mirror_reserve(r.dev, r.addr, r.nblk, e.start);
      rea_pkg::FnCommit: begin
        mirror_commit(r.gen);
        e.status = rea_pkg::StOk;
      end
      rea_pkg::FnFree, rea_pkg::FnRef, rea_pkg::FnLookup: begin
        k = find_extent(r.addr);
        if (r.dev != 0) e.status = rea_pkg::StInvalid;
        else if (k < 0) e.status = rea_pkg::StNotFound;
        else if (r.func == rea_pkg::FnLookup) begin
          e.status = rea_pkg::StOk;
          e.len = ext_len[k];
          e.refs = ext_refs[k];
        end else if (ext_refs[k] == 0) begin
          e.status = rea_pkg::StInvalid;  // double free, ref of pending
        end else if (r.func == rea_pkg::FnRef) begin
          if (ext_refs[k] >= rea_pkg::RefLimit) e.status = rea_pkg::StRange;
          else begin
            ext_refs[k]++;
            e.status = rea_pkg::StOk;
          end
        end else begin
          ext_refs[k]--;
          if (ext_refs[k] == 0) begin
            ext_gen[k] = r.gen;
            alloc_total -= ext_len[k];
            pend_total += ext_len[k];
          end
          e.status = rea_pkg::StOk;
        end
      end
      default: e.status = rea_pkg::StInvalid;
    endcase
    e.alloc = alloc_total;
    e.pend = pend_total;
    return e;
  endfunction

  // Issue one request; called and returning at a falling edge, valid left high.
  task automatic send_request(stim_row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    func_i          = r.func;
    device_index_i  = r.dev;
    address_block_i = r.addr;
    nblocks_i       = r.nblk;
    generation_i    = r.gen;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_replies.push_back(predict_request(r));
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [2:0] f, logic [3:0] d, logic [31:0] a,
                         logic [31:0] n, logic [31:0] g);
    stim_row_t r;
    r = '{f, d, a, n, g, 1'b0, rea_pkg::StOk};
    send_request(r);
  endtask

  // Hold the sender until every awaited reply has arrived, then let the block settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rea_pkg::RegFirst) area_first = data;
    else area_last = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Release every live reference and commit everything, to keep scans short.
  task automatic empty_table();
    logic [31:0] starts[$];
    for (int i = 0; i < ext_cnt; i++) starts.push_back(ext_start[i]);
    foreach (starts[j]) begin
      while (find_extent(starts[j]) >= 0 && ext_refs[find_extent(starts[j])] != 0)
        send_op(rea_pkg::FnFree, 4'd0, starts[j], '0, epoch);
    end
    send_op(rea_pkg::FnCommit, 4'd0, '0, '0, 32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pick_start();
    if (ext_cnt == 0 || $urandom_range(9) == 0) return $urandom;
    return ext_start[$urandom_range(ext_cnt - 1)];
  endfunction

  // Idling mode follows progress through the random part.
  function automatic void set_idling();
    if (random_sent < 165) begin
      send_idle_pct = 17; recv_stall_pct = 68;
    end else if (random_sent < 330) begin
      send_idle_pct = 68; recv_stall_pct = 17;
    end else begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end
  endfunction

  task automatic random_request();
    int          sel;
    logic [3:0]  dev;
    logic [31:0] n, hint;
    set_idling();
    sel = $urandom_range(99);
    dev = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd0;
    random_sent++;
    if (sel < 35) begin
      case ($urandom_range(9))
        0:       n = $urandom;
        1:       n = '0;
        default: n = $urandom_range(64, 1);
      endcase
      case ($urandom_range(3))
        0:       hint = '0;
        1:       hint = $urandom;
        default: hint = area_first + $urandom_range(3000) - 5;
      endcase
      send_op(rea_pkg::FnReserve, dev, hint, n, $urandom);
    end else if (sel < 55) begin
      send_op(rea_pkg::FnFree, dev, pick_start(), $urandom,
              ($urandom_range(15) == 0) ? $urandom : epoch + $urandom_range(3));
    end else if (sel < 70) begin
      send_op(rea_pkg::FnRef, dev, pick_start(), $urandom, $urandom);
    end else if (sel < 90) begin
      send_op(rea_pkg::FnLookup, dev, pick_start(), $urandom, $urandom);
    end else if (sel < 97) begin
      send_op(rea_pkg::FnCommit, 4'($urandom), $urandom, $urandom,
              ($urandom_range(9) == 0) ? $urandom : epoch);
      epoch += $urandom_range(2);
    end else begin
      send_op(3'($urandom_range(7, 5)), 4'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  function automatic void add_row(logic [2:0] f, logic [3:0] d, logic [31:0] a,
                                  logic [31:0] n, logic [31:0] g, bit typed,
                                  logic [2:0] st);
    stim_row_t r;
    r = '{f, d, a, n, g, typed, st};
    directed_rows.push_back(r);
  endfunction

  // Compare one field; report and count a mismatch.
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Check every delivered result against the oldest awaited reply.
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, status_o);
      end else begin
        e = awaited_replies.pop_front();
        check_field("status", 32'(e.status), 32'(status_o));
        if (e.typed) check_field("status (table)", 32'(e.typed_status), 32'(status_o));
        check_field("extent_base", e.start, extent_base_o);
        check_field("extent_size", e.len, extent_size_o);
        check_field("ref_count", e.refs, ref_count_o);
        check_field("live_total", e.alloc, live_total_o);
        check_field("held_total", e.pend, held_total_o);
      end
    end
  end

  initial begin
    logic [31:0] phase_first [5];
    logic [31:0] phase_last  [5];
    errors = 0;
    epoch = 32'd1;
    random_sent = 0;
    send_idle_pct = 17;
    recv_stall_pct = 68;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i = '0;
    device_index_i = '0;
    address_block_i = '0;
    nblocks_i = '0;
    generation_i = '0;
    ext_cnt = 0;
    alloc_total = '0;
    pend_total = '0;
    area_first = '0;
    area_last = 32'hFFFF_FFFF;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, extremes, the invalid, no-space and not-found codes.
    add_row(rea_pkg::FnLookup, 4'd0, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StNotFound);
    add_row(3'd5, 4'd0, 32'd0, 32'd1, 32'd0, 1, rea_pkg::StInvalid);
    add_row(3'd7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            rea_pkg::StInvalid);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd0, 32'd1, 32'd0, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd0, 32'd1, 32'd0, 1, rea_pkg::StNoSpace);
    add_row(rea_pkg::FnFree, 4'd0, 32'd1, 32'd0, 32'h7FFF_FFFF, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnLookup, 4'd0, 32'd1, 32'd0, 32'd0, 0, rea_pkg::StOk);
    add_row(rea_pkg::FnFree, 4'd0, 32'd1, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnRef, 4'd0, 32'd1, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnRef, 4'hF, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnFree, 4'd8, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnLookup, 4'd1, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StInvalid);
    add_row(rea_pkg::FnRef, 4'd0, 32'd0, 32'd0, 32'd0, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnLookup, 4'd0, 32'd0, 32'd0, 32'd0, 0, rea_pkg::StOk);
    add_row(rea_pkg::FnFree, 4'd0, 32'd12345, 32'd0, 32'd0, 1, rea_pkg::StNotFound);
    add_row(rea_pkg::FnRef, 4'd0, 32'd12345, 32'd0, 32'd0, 1, rea_pkg::StNotFound);
    add_row(rea_pkg::FnCommit, 4'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnCommit, 4'd0, 32'd0, 32'd0, 32'h8000_0000, 1, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd100, 32'd10, 32'd0, 0, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd3, 32'd50, 32'd60, 32'd0, 0, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd0, 32'd20, 32'd5, 32'd0, 0, rea_pkg::StOk);
    add_row(rea_pkg::FnReserve, 4'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 0, rea_pkg::StOk);
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain();
    empty_table();
    drain();

    // Fill the table to its depth, then overflow it and walk it back down.
    write_reg(rea_pkg::RegFirst, 32'd0);
    write_reg(rea_pkg::RegLast, 32'hFFFF_FFFF);
    for (int i = 0; i < rea_pkg::TableDepth + 4; i++)
      send_op(rea_pkg::FnReserve, 4'd0, '0, 32'd1, '0);
    for (int i = 0; i < 6; i++) send_op(rea_pkg::FnLookup, 4'd0, pick_start(), '0, '0);
    drain();
    empty_table();
    drain();

    // Random phases over several data areas, the extremes among them.
    phase_first = '{32'd0,         32'd1000, 32'd0, 32'hFFFF_FF00, 32'hFFFF_FFFF};
    phase_last  = '{32'hFFFF_FFFF, 32'd4999, 32'd0, 32'hFFFF_FFFF, 32'd0};
    for (int p = 0; p < 5; p++) begin
      write_reg(rea_pkg::RegFirst, phase_first[p]);
      write_reg(rea_pkg::RegLast, phase_last[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        random_request();
        if (p == 1 && i == 40) drain();  // pause the sender until all replies are in
      end
      // Move the area under a live table once, then clean up.
      if (p == 1) begin
        drain();
        write_reg(rea_pkg::RegFirst, 32'd3000);
        for (int i = 0; i < 40; i++) random_request();
      end
      drain();
      empty_table();
      drain();
    end
    write_reg(rea_pkg::RegFirst, 32'd0);
    write_reg(rea_pkg::RegLast, 32'hFFFF_FFFF);
    for (int i = 0; i < 60; i++) random_request();

    drain();
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
